FILE: sv/tfn_pkg.sv
// Package for the triangle face normal block: fixed-point constants shared
// by the top level. Depends on nothing.
package tfn_pkg;

   // Width of one normal component at the result ports (signed Q2.14).
   localparam int OUT_W = 16;
   // Value of one in Q2.14.
   localparam int UNIT_ONE = 16384;
   // Largest length that still counts as a degenerate triangle.
   localparam int EPS_LIMIT = 16;
   // Scale of the numerator: n * 2^15 + L over 2L gives n * 16384 / L, rounded.
   localparam int NUM_SHIFT = 15;
   // Quotient bits: the quotient never exceeds 16384.
   localparam int QUO_W = 15;

endpackage

FILE: sv/triangle_face_normal.sv
// Top level of the triangle face normal block: edges, cross product,
// pipelined square root and pipelined divide. Depends on tfn_pkg.
//
//  Channel   Ports                         Transfer happens when
//  --------  ----------------------------  ------------------------------
//  input     req_ax .. req_cz              start high and busy low
//  result    rsp_unit_x/y/z, rsp_degenerate rsp_valid high (one cycle)
//
// Every triangle passes the input, edge, product, cross product and partial
// square registers, the one-bit-per-stage square root (LEN_W stages), the
// one-bit-per-stage divider (QUO_W stages) and the result register.
// A new triangle may be transferred in every cycle; busy is always low.
// Reset clears only the valid bits that travel with the data. The receiver
// cannot stall, so nothing in the pipeline ever waits.
module triangle_face_normal #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_ax,
   input  logic signed [COORD_WIDTH-1:0] req_ay,
   input  logic signed [COORD_WIDTH-1:0] req_az,
   input  logic signed [COORD_WIDTH-1:0] req_bx,
   input  logic signed [COORD_WIDTH-1:0] req_by,
   input  logic signed [COORD_WIDTH-1:0] req_bz,
   input  logic signed [COORD_WIDTH-1:0] req_cx,
   input  logic signed [COORD_WIDTH-1:0] req_cy,
   input  logic signed [COORD_WIDTH-1:0] req_cz,
   output logic                          rsp_valid,
   output logic signed [tfn_pkg::OUT_W-1:0] rsp_unit_x,
   output logic signed [tfn_pkg::OUT_W-1:0] rsp_unit_y,
   output logic signed [tfn_pkg::OUT_W-1:0] rsp_unit_z,
   output logic                          rsp_degenerate
);

   localparam int CW    = COORD_WIDTH;
   localparam int EW    = CW + 1;          // edge width
   localparam int PW    = 2 * EW;          // product width
   localparam int MW    = 2 * CW + 2;      // magnitude width of a normal component
   localparam int HW    = MW / 2;          // half of a magnitude for the squares
   localparam int SW    = 2 * MW + 2;      // sum of squares width
   localparam int LEN_W = MW + 1;          // square root width
   localparam int QW    = tfn_pkg::QUO_W;
   localparam int NUMW  = MW + tfn_pkg::NUM_SHIFT + 1;
   localparam int OW    = tfn_pkg::OUT_W;

   // The pipeline never holds off an input.
   assign busy = 1'b0;

   // ---------------------------------------------------------------- input
   logic                 v_in_ff;
   logic signed [CW-1:0] crd_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff <= 1'b0;
      end else begin
         v_in_ff <= start;
      end
      crd_ff[0] <= req_ax;
      crd_ff[1] <= req_ay;
      crd_ff[2] <= req_az;
      crd_ff[3] <= req_bx;
      crd_ff[4] <= req_by;
      crd_ff[5] <= req_bz;
      crd_ff[6] <= req_cx;
      crd_ff[7] <= req_cy;
      crd_ff[8] <= req_cz;
   end

   // ---------------------------------------------------------------- edges
   // Order: e1x, e1y, e1z, e2x, e2y, e2z.
   logic                 v_edge_ff;
   logic signed [EW-1:0] edge_ff [0:5];
   logic signed [EW-1:0] edge_in [0:5];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         edge_in[k]   = EW'(crd_ff[3+k]) - EW'(crd_ff[k]);
         edge_in[3+k] = EW'(crd_ff[6+k]) - EW'(crd_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_edge_ff <= 1'b0;
      end else begin
         v_edge_ff <= v_in_ff;
      end
      edge_ff <= edge_in;
   end

   // ------------------------------------------------------------- products
   // Each normal component is the difference of products 2k and 2k+1.
   logic                 v_prod_ff;
   logic signed [PW-1:0] prod_ff [0:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_prod_ff <= 1'b0;
      end else begin
         v_prod_ff <= v_edge_ff;
      end
      prod_ff[0] <= edge_ff[1] * edge_ff[5];
      prod_ff[1] <= edge_ff[2] * edge_ff[4];
      prod_ff[2] <= edge_ff[2] * edge_ff[3];
      prod_ff[3] <= edge_ff[0] * edge_ff[5];
      prod_ff[4] <= edge_ff[0] * edge_ff[4];
      prod_ff[5] <= edge_ff[1] * edge_ff[3];
   end

   // ------------------------------------------------------- cross product
   logic                 v_crs_ff;
   logic [MW-1:0]        mag_crs_ff [0:2];
   logic                 neg_crs_ff [0:2];
   logic signed [MW:0]   nrm_in     [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nrm_in[k] = (MW+1)'(prod_ff[2*k]) - (MW+1)'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_crs_ff <= 1'b0;
      end else begin
         v_crs_ff <= v_prod_ff;
      end
      for (int k = 0; k < 3; k++) begin
         neg_crs_ff[k] <= nrm_in[k][MW];
         mag_crs_ff[k] <= nrm_in[k][MW] ? MW'(-nrm_in[k]) : MW'(nrm_in[k]);
      end
   end

   // --------------------------------------------------- partial squares
   // Each magnitude is split into two halves so that no multiplier exceeds
   // HW by HW bits; the three partial products are summed in the next stage.
   logic                 v_part_ff;
   logic [MW-1:0]        sq_hh_ff [0:2];
   logic [MW-1:0]        sq_hl_ff [0:2];
   logic [MW-1:0]        sq_ll_ff [0:2];
   logic [MW-1:0]        mag_part_ff [0:2];
   logic                 neg_part_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_part_ff <= 1'b0;
      end else begin
         v_part_ff <= v_crs_ff;
      end
      for (int k = 0; k < 3; k++) begin
         sq_hh_ff[k]    <= mag_crs_ff[k][MW-1:HW] * mag_crs_ff[k][MW-1:HW];
         sq_hl_ff[k]    <= mag_crs_ff[k][MW-1:HW] * mag_crs_ff[k][HW-1:0];
         sq_ll_ff[k]    <= mag_crs_ff[k][HW-1:0] * mag_crs_ff[k][HW-1:0];
         mag_part_ff[k] <= mag_crs_ff[k];
         neg_part_ff[k] <= neg_crs_ff[k];
      end
   end

   // -------------------------------------------------------- sum of squares
   logic [SW-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 3; k++) begin
         sum_in = sum_in + (SW'(sq_hh_ff[k]) << MW) + (SW'(sq_hl_ff[k]) << (HW + 1))
                  + SW'(sq_ll_ff[k]);
      end
   end

   // Square root pipeline: stage s decides root bit LEN_W-1-s. Index 0 holds
   // the sum of squares with an empty root; index LEN_W holds the floor root.
   logic                 v_sq_ff   [0:LEN_W];
   logic [SW-1:0]        rem_sq_ff [0:LEN_W];
   logic [LEN_W-1:0]     root_ff   [0:LEN_W];
   logic [MW-1:0]        mag_sq_ff [0:LEN_W][0:2];
   logic                 neg_sq_ff [0:LEN_W][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_sq_ff[0] <= 1'b0;
      end else begin
         v_sq_ff[0] <= v_part_ff;
      end
      rem_sq_ff[0] <= sum_in;
      root_ff[0]   <= '0;
      mag_sq_ff[0] <= mag_part_ff;
      neg_sq_ff[0] <= neg_part_ff;
   end

   for (genvar s = 0; s < LEN_W; s++) begin : g_sqrt
      localparam int BIT = LEN_W - 1 - s;
      logic [SW:0]      trial;
      logic             take;
      logic [SW-1:0]    rem_in;
      logic [LEN_W-1:0] root_in;

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      always_comb begin
         trial   = ((SW+1)'(root_ff[s]) << (BIT + 1)) + ((SW+1)'(1) << (2 * BIT));
         take    = (SW+1)'(rem_sq_ff[s]) >= trial;
         rem_in  = take ? SW'((SW+1)'(rem_sq_ff[s]) - trial) : rem_sq_ff[s];
         root_in = take ? (root_ff[s] | (LEN_W'(1) << BIT)) : root_ff[s];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_sq_ff[s+1] <= 1'b0;
         end else begin
            v_sq_ff[s+1] <= v_sq_ff[s];
         end
         rem_sq_ff[s+1] <= rem_in;
         root_ff[s+1]   <= root_in;
         mag_sq_ff[s+1] <= mag_sq_ff[s];
         neg_sq_ff[s+1] <= neg_sq_ff[s];
      end
   end

   // Divider pipeline: quotient of (|n| * 2^15 + L) / (2L), one bit a stage
   // from the top. Since |n| <= L the quotient fits in QW bits.
   logic              v_dv_ff   [0:QW];
   logic [NUMW-1:0]   rem_dv_ff [0:QW][0:2];
   logic [QW-1:0]     quo_ff    [0:QW][0:2];
   logic [LEN_W:0]    den_ff    [0:QW];
   logic              neg_dv_ff [0:QW][0:2];
   logic              dgn_ff    [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_dv_ff[0] <= 1'b0;
      end else begin
         v_dv_ff[0] <= v_sq_ff[LEN_W];
      end
      for (int k = 0; k < 3; k++) begin
         rem_dv_ff[0][k] <= (NUMW'(mag_sq_ff[LEN_W][k]) << tfn_pkg::NUM_SHIFT)
                            + NUMW'(root_ff[LEN_W]);
         quo_ff[0][k]    <= '0;
      end
      den_ff[0]    <= {root_ff[LEN_W], 1'b0};
      neg_dv_ff[0] <= neg_sq_ff[LEN_W];
      dgn_ff[0]    <= root_ff[LEN_W] <= LEN_W'(tfn_pkg::EPS_LIMIT);
   end

   for (genvar s = 0; s < QW; s++) begin : g_div
      localparam int BIT = QW - 1 - s;
      logic [NUMW:0]   dsh;
      logic [NUMW-1:0] rem_in [0:2];
      logic [QW-1:0]   quo_in [0:2];

      always_comb begin
         dsh = (NUMW+1)'(den_ff[s]) << BIT;
         for (int k = 0; k < 3; k++) begin
            if ((NUMW+1)'(rem_dv_ff[s][k]) >= dsh) begin
               rem_in[k] = NUMW'((NUMW+1)'(rem_dv_ff[s][k]) - dsh);
               quo_in[k] = quo_ff[s][k] | (QW'(1) << BIT);
            end else begin
               rem_in[k] = rem_dv_ff[s][k];
               quo_in[k] = quo_ff[s][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_dv_ff[s+1] <= 1'b0;
         end else begin
            v_dv_ff[s+1] <= v_dv_ff[s];
         end
         rem_dv_ff[s+1] <= rem_in;
         quo_ff[s+1]    <= quo_in;
         den_ff[s+1]    <= den_ff[s];
         neg_dv_ff[s+1] <= neg_dv_ff[s];
         dgn_ff[s+1]    <= dgn_ff[s];
      end
   end

   // ---------------------------------------------------------------- result
   // Saturate to one, apply the sign, and force zero on a degenerate triangle.
   logic                 rsp_valid_ff;
   logic signed [OW-1:0] unit_ff [0:2];
   logic signed [OW-1:0] unit_in [0:2];
   logic                 dgn_out_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [OW-1:0] sat;
         sat = (OW'(quo_ff[QW][k]) > OW'(tfn_pkg::UNIT_ONE)) ? OW'(tfn_pkg::UNIT_ONE)
               : OW'(quo_ff[QW][k]);
         if (dgn_ff[QW]) begin
            unit_in[k] = '0;
         end else if (neg_dv_ff[QW][k]) begin
            unit_in[k] = -$signed(sat);
         end else begin
            unit_in[k] = $signed(sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v_dv_ff[QW];
      end
      unit_ff    <= unit_in;
      dgn_out_ff <= dgn_ff[QW];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_unit_x     = unit_ff[0];
   assign rsp_unit_y     = unit_ff[1];
   assign rsp_unit_z     = unit_ff[2];
   assign rsp_degenerate = dgn_out_ff;

endmodule
